[design/tmb_pkg.sv]
// shared types and constants for the temporal median background block
package tmb_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int CFG_W          = 7;
    localparam int CFG_IDX_W      = 1;
    localparam int MAX_FRAMES_DEF = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID = 1'd1;

    // what one cell hands to the next cell up the chain
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                shift;
    } t_link;

endpackage

[design/temporal_median_background.sv]
// temporal median background builder: top level with sorted cell chain
// Builds a per-pixel depth background from a stream of samples that carries the
// samples of one pixel back to back, one per frame. Zero samples are invalid and
// skipped; nonzero samples are insertion-sorted into a row of MAX_FRAMES cells,
// every cell comparing the new sample and taking it, its lower neighbor's value
// or its own in the same cycle. After the configured number of frames one
// item comes out: the median of the valid samples (middle value, or the mean of
// the two middle values rounded half up), or 0 when fewer than min_valid_count
// were valid.
// One sample is taken per cycle. The last sample of a pixel waits only while a
// result sits in both the median holding stage and the output register; this
// occurs with a result per sample even for an always-ready sink. A result is
// registered in the median holding stage, then the output register. The user must
// write registers via i_cfg_we/i_cfg_idx/i_cfg_wdata only while idle; not enforced.
module temporal_median_background
    import tmb_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [SAMPLE_W-1:0]  i_s_axis_tdata,   // [15:0] depth_sample
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [SAMPLE_W-1:0]  o_m_axis_tdata    // [15:0] plate_depth
);

    // counts run up to MAX_FRAMES itself
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int KW = (CW > CFG_W) ? CW : CFG_W;

    logic [CFG_W-1:0]    r_frames;
    logic [CFG_W-1:0]    r_min_valid;
    logic [CW-1:0]       r_samples_seen;
    logic [CW-1:0]       r_valid_seen;
    logic [CW-1:0]       n_samples_seen;
    logic [CW-1:0]       n_valid_seen;

    logic [KW-1:0]       w_eff_frames;
    logic [KW-1:0]       w_need;
    logic [CW-1:0]       w_seen_inc;
    logic [CW-1:0]       w_count;
    logic [CW-1:0]       w_mid;
    logic [CW-1:0]       w_lo_idx;
    logic                w_final;
    logic                w_ins;
    logic                w_accept;
    logic                w_known;
    logic                w_full;
    logic [SAMPLE_W-1:0] w_lo;
    logic [SAMPLE_W-1:0] w_hi;

    t_link               w_link [MAX_FRAMES];
    logic [SAMPLE_W-1:0] w_next [MAX_FRAMES];

    // zero frame count acts as one, large counts saturate at the chain length
    always_comb begin
        if (r_frames == '0) begin
            w_eff_frames = KW'(1);
        end else if (KW'(r_frames) > KW'(MAX_FRAMES)) begin
            w_eff_frames = KW'(MAX_FRAMES);
        end else begin
            w_eff_frames = KW'(r_frames);
        end
        w_need = (r_min_valid == '0) ? KW'(1) : KW'(r_min_valid);
    end

    assign w_seen_inc = (r_samples_seen < CW'(MAX_FRAMES)) ? r_samples_seen + CW'(1)
                                                           : r_samples_seen;
    assign w_final    = KW'(w_seen_inc) >= w_eff_frames;
    assign w_ins      = (i_s_axis_tdata != '0) && (r_valid_seen < CW'(MAX_FRAMES));

    // only the last sample of a pixel needs room in the result stages
    assign o_s_axis_tready = !w_final || !w_full;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // valid count including the sample of this cycle
    assign w_count  = r_valid_seen + CW'(w_ins);
    assign w_known  = (KW'(w_count) >= w_need) && (w_count != '0);
    assign w_mid    = w_count >> 1;
    assign w_lo_idx = w_count[0] ? w_mid : w_mid - CW'(1);

    always_comb begin
        n_samples_seen = r_samples_seen;
        n_valid_seen   = r_valid_seen;
        if (w_accept) begin
            if (w_final) begin
                n_samples_seen = '0;
                n_valid_seen   = '0;
            end else begin
                n_samples_seen = w_seen_inc;
                n_valid_seen   = w_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames       <= CFG_W'(1);
            r_min_valid    <= CFG_W'(1);
            r_samples_seen <= '0;
            r_valid_seen   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAMES:    r_frames    <= i_cfg_wdata;
                    CFG_MIN_VALID: r_min_valid <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_samples_seen <= n_samples_seen;
            r_valid_seen   <= n_valid_seen;
        end
    end

    // sorted chain, lowest value in cell zero
    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        t_link w_prev;
        if (g == 0) begin : g_head
            assign w_prev = '{value: '0, shift: 1'b0};
        end else begin : g_body
            assign w_prev = w_link[g-1];
        end
        tmb_cell u_cell (
            .i_clk       (i_clk),
            .i_sample    (i_s_axis_tdata),
            .i_insert    (w_accept && w_ins),
            .i_valid     (r_valid_seen > CW'(g)),
            .i_prev      (w_prev),
            .o_link      (w_link[g]),
            .o_next_value(w_next[g])
        );
    end

    // pick the middle pair from the chain as it stands after this insert
    always_comb begin
        w_lo = '0;
        w_hi = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (w_mid == CW'(i)) begin
                w_hi = w_hi | w_next[i];
            end
            if (w_lo_idx == CW'(i)) begin
                w_lo = w_lo | w_next[i];
            end
        end
    end

    tmb_median u_median (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_accept && w_final),
        .i_known        (w_known),
        .i_lo           (w_lo),
        .i_hi           (w_hi),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_full         (w_full)
    );

`ifndef SYNTH
    a_valid_le_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid_seen <= r_samples_seen)
        else $error("more valid samples than samples of the pixel");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_final && w_ins) |=> (r_valid_seen == $past(r_valid_seen) + CW'(1)))
        else $error("valid count did not follow an inserted sample");

    a_pixel_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_final) |=> (r_samples_seen == '0 && r_valid_seen == '0))
        else $error("counts not cleared after the last sample of a pixel");
`endif

endmodule

[design/tmb_cell.sv]
// one slot of the sorted sample chain
module tmb_cell
    import tmb_pkg::*;
(
    input  logic                i_clk,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_insert,
    input  logic                i_valid,
    input  t_link               i_prev,
    output t_link               o_link,
    output logic [SAMPLE_W-1:0] o_next_value
);

    logic [SAMPLE_W-1:0] r_value;
    logic [SAMPLE_W-1:0] n_value;
    logic                w_greater;

    assign w_greater = i_valid && (r_value > i_sample);

    // lower neighbor moving up wins, else the sample lands in the first empty or greater cell
    always_comb begin
        n_value = r_value;
        if (i_insert) begin
            if (i_prev.shift) begin
                n_value = i_prev.value;
            end else if (!i_valid || w_greater) begin
                n_value = i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.value = r_value;
    assign o_link.shift = w_greater;
    assign o_next_value = n_value;

endmodule

[design/tmb_median.sv]
// median holding stage and rounded-mean output register
module tmb_median
    import tmb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_known,
    input  logic [SAMPLE_W-1:0] i_lo,
    input  logic [SAMPLE_W-1:0] i_hi,
    input  logic                i_m_axis_tready,
    output logic                o_m_axis_tvalid,
    output logic [SAMPLE_W-1:0] o_m_axis_tdata,
    output logic                o_full
);

    logic                r_s_valid;
    logic                r_s_known;
    logic [SAMPLE_W-1:0] r_s_lo;
    logic [SAMPLE_W-1:0] r_s_hi;
    logic                r_o_valid;
    logic [SAMPLE_W-1:0] r_o_data;
    logic                w_move;
    logic [SAMPLE_W:0]   w_sum;

    assign w_move = r_s_valid && (!r_o_valid || i_m_axis_tready);
    assign w_sum  = {1'b0, r_s_lo} + {1'b0, r_s_hi} + {{SAMPLE_W{1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_s_valid <= 1'b1;
            end else if (w_move) begin
                r_s_valid <= 1'b0;
            end
            if (w_move) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s_known <= i_known;
            r_s_lo    <= i_lo;
            r_s_hi    <= i_hi;
        end
        if (w_move) begin
            r_o_data <= r_s_known ? w_sum[SAMPLE_W:1] : '0;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_full          = r_s_valid && r_o_valid;

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_load && r_s_valid && r_o_valid))
        else $error("median stage loaded while both stages hold a result");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_valid && !r_o_valid) |=> r_o_valid)
        else $error("held median did not reach the output register");
`endif

endmodule

[tb/sv/temporal_median_background_tb.sv]
// self-checking testbench for the temporal median background builder
module temporal_median_background_tb;
    import tmb_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 8;   // margin for a pixel's result to come out of the block
    localparam int HOLD_CYCLES = 150;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    // block inputs, all known from time zero
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_FRAMES;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic [SAMPLE_W-1:0]  i_s_axis_tdata = '0;   // [15:0] depth_sample
    logic                 i_m_axis_tready = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [SAMPLE_W-1:0]  o_m_axis_tdata;        // [15:0] plate_depth

    temporal_median_background u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // stimulus bookkeeping
    logic [SAMPLE_W-1:0] pending_samples[$];   // depth samples not yet offered
    int                  samples_owed = 0;     // queued but not yet accepted
    logic [SAMPLE_W-1:0] last_depth = '0;      // for repeated-value samples
    bit                  quiet = 1'b0;         // no idling on either side
    bit                  hold_request = 1'b0;  // ask the sink for one long stall
    int                  error_count = 0;
    int                  cycle_count = 0;

    // predictor state: configuration copy and the per-pixel sorted store
    logic [CFG_W-1:0]    frame_cfg = 7'd1;
    logic [CFG_W-1:0]    min_valid_cfg = 7'd1;
    logic [SAMPLE_W-1:0] depth_store[MAX_FRAMES_DEF];
    int                  valid_seen = 0;
    int                  samples_seen = 0;
    logic [SAMPLE_W-1:0] plate_depth_q[$];    // expected background depths

    // frame count as the block uses it: zero means one, clipped at the store size
    function automatic int frames_per_pixel();
        if (frame_cfg == 0) begin
            return 1;
        end
        if (frame_cfg > MAX_FRAMES_DEF) begin
            return MAX_FRAMES_DEF;
        end
        return frame_cfg;
    endfunction

    // one accepted sample: sort it in, and close the pixel when enough have come
    task automatic take_depth_sample(input logic [SAMPLE_W-1:0] sample);
        int                  pos;
        int                  need;
        logic [SAMPLE_W:0]   pair_sum;
        logic [SAMPLE_W-1:0] plate;
        if (sample != 0 && valid_seen < MAX_FRAMES_DEF) begin
            pos = valid_seen;
            while (pos > 0 && depth_store[pos-1] > sample) begin
                depth_store[pos] = depth_store[pos-1];
                pos--;
            end
            depth_store[pos] = sample;
            valid_seen++;
        end
        if (samples_seen < MAX_FRAMES_DEF) begin
            samples_seen++;
        end
        // checked against the current count, so a lowered count closes at once
        if (samples_seen >= frames_per_pixel()) begin
            need = (min_valid_cfg == 0) ? 1 : min_valid_cfg;
            if (valid_seen < need || valid_seen == 0) begin
                plate = '0;
            end else if (valid_seen % 2 == 1) begin
                plate = depth_store[valid_seen/2];
            end else begin
                // mean of the two middle values, half rounds up
                pair_sum = depth_store[valid_seen/2 - 1] + depth_store[valid_seen/2] + 1'b1;
                plate = pair_sum[SAMPLE_W:1];
            end
            plate_depth_q.push_back(plate);
            valid_seen = 0;
            samples_seen = 0;
        end
    endtask

    task automatic flag_mismatch(input string what);
        $display("error at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // random depth: invalid zeros, repeats, both ends of the range, anything
    function automatic logic [SAMPLE_W-1:0] pick_depth();
        logic [SAMPLE_W-1:0] value;
        case ($urandom_range(0, 9))
            0, 1: begin
                value = '0;
            end
            2: begin
                value = last_depth;
            end
            3: begin
                value = SAMPLE_W'($urandom_range(1, 15));
            end
            4: begin
                value = SAMPLE_W'($urandom_range(65520, 65535));
            end
            default: begin
                value = SAMPLE_W'($urandom_range(0, 65535));
            end
        endcase
        last_depth = value;
        return value;
    endfunction

    task automatic offer_sample(input logic [SAMPLE_W-1:0] sample);
        pending_samples.push_back(sample);
        samples_owed++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        // the block is idle, so the copy may change right away
        if (idx == CFG_FRAMES) begin
            frame_cfg = value;
        end else begin
            min_valid_cfg = value;
        end
    endtask

    // wait until every sample is taken and every result is back,
    // then give a pixel in progress time to finish inside the block
    task automatic settle();
        while (samples_owed != 0 || plate_depth_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] frames,
                                 input logic [CFG_W-1:0] min_valid);
        settle();
        write_register(CFG_FRAMES, frames);
        write_register(CFG_MIN_VALID, min_valid);
    endtask

    // sample source: holds an item until taken, idles in short random bursts
    int source_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            source_gap <= 0;
        end else if (i_s_axis_tvalid && !o_s_axis_tready) begin
            // item still on offer, keep it steady
        end else if (source_gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            source_gap <= source_gap - 1;
        end else if (pending_samples.size() != 0) begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
                i_s_axis_tvalid <= 1'b0;
                source_gap <= $urandom_range(0, 4);
            end else begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= pending_samples.pop_front();
            end
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // result sink: random stall bursts, plus one long stall on request
    int  sink_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (quiet) begin
            i_m_axis_tready <= 1'b1;
        end else if (sink_gap != 0) begin
            i_m_axis_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_m_axis_tready <= 1'b0;
            sink_gap <= $urandom_range(0, 4);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // monitor: predicts on every accepted sample, checks every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                take_depth_sample(i_s_axis_tdata);
                samples_owed--;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (plate_depth_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected plate_depth %0d", o_m_axis_tdata));
                end else if (o_m_axis_tdata !== plate_depth_q[0]) begin
                    flag_mismatch($sformatf("plate_depth %0d, expected %0d",
                                            o_m_axis_tdata, plate_depth_q[0]));
                    void'(plate_depth_q.pop_front());
                end else begin
                    void'(plate_depth_q.pop_front());
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int fc;
        int mv;
        int pixel_samples;
        int random_samples;
        random_samples = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: one sample per pixel, zero gives unknown
        offer_sample(16'd0);
        offer_sample(16'd1);
        offer_sample(16'hFFFF);
        offer_sample(16'hAAAA);
        offer_sample(16'h5555);

        // zero frame count and zero minimum both act as one
        apply_setting(7'd0, 7'd0);
        offer_sample(16'd0);
        offer_sample(16'd7);

        // four frames, two valid needed: too few valid, odd count, even count
        apply_setting(7'd4, 7'd2);
        offer_sample(16'd0);
        offer_sample(16'd0);
        offer_sample(16'd5);
        offer_sample(16'd0);
        offer_sample(16'd10);
        offer_sample(16'd3);
        offer_sample(16'd0);
        offer_sample(16'hFFFF);
        offer_sample(16'hFFFF);
        offer_sample(16'hFFFE);
        offer_sample(16'd1);
        offer_sample(16'd2);

        // minimum above the frame count: always unknown
        apply_setting(7'd3, 7'd5);
        offer_sample(16'd1);
        offer_sample(16'd2);
        offer_sample(16'd3);

        // frame count lowered in the middle of a pixel closes it on the next sample
        apply_setting(7'd6, 7'd1);
        offer_sample(16'd9);
        offer_sample(16'd0);
        offer_sample(16'd4);
        settle();
        write_register(CFG_FRAMES, 7'd2);
        offer_sample(16'd8);

        // pixel as long as the store at the maximum frame count
        apply_setting(7'd64, 7'd1);
        repeat (64) offer_sample(pick_depth());

        // frame count above the store size saturates
        apply_setting(7'd127, 7'd33);
        repeat (64) offer_sample(pick_depth());

        // largest minimum: nothing is ever known
        apply_setting(7'd1, 7'd127);
        repeat (6) offer_sample(pick_depth());

        // long sink stall with a result per sample, so the block backs up
        apply_setting(7'd1, 7'd1);
        hold_request = 1'b1;
        repeat (40) offer_sample(pick_depth());
        random_samples = 200;

        // random settings, mostly whole pixels, sometimes a pixel left open
        while (random_samples < 340) begin
            if ($urandom_range(0, 4) == 0) begin
                fc = $urandom_range(9, 24);
            end else begin
                fc = $urandom_range(1, 8);
            end
            mv = $urandom_range(0, fc + 1);
            apply_setting(CFG_W'(fc), CFG_W'(mv));
            pixel_samples = (fc > 8 ? $urandom_range(1, 3) : $urandom_range(2, 6))
                            * frames_per_pixel();
            if ($urandom_range(0, 3) == 0) begin
                pixel_samples += $urandom_range(1, 2);
            end
            repeat (pixel_samples) offer_sample(pick_depth());
            random_samples += pixel_samples;
        end

        // closing stretch at full rate on both sides
        apply_setting(7'd3, 7'd2);
        quiet = 1'b1;
        repeat (60) offer_sample(pick_depth());

        settle();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[temporal_median_background.f]
design/tmb_pkg.sv
design/tmb_cell.sv
design/tmb_median.sv
design/temporal_median_background.sv
tb/sv/temporal_median_background_tb.sv
